// ===== hdl/i2c_master_bit_sequencer_top_macros.svh =====
// ----------------------------------------------------------------------------
// I2C bit sequencer assertion macros
// Clocked assertion shorthands used by the checker; they expect clk_i and
// rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_TOP_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_TOP_MACROS_SVH

// property must hold at every clock edge outside reset
`define I2CBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// expression must never be true outside reset
`define I2CBS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ===== hdl/i2cbs_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C bit sequencer package
// Shared constants, command and register codes, and transaction types.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbs_pkg;

  localparam int unsigned DATA_BITS  = 8;
  localparam int unsigned WAIT_W     = 16;
  localparam int unsigned LEAD_W     = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned BIT_IDX_W  = $clog2(DATA_BITS + 1);

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_START   = 3'd1,
    ACT_STOP    = 3'd2,
    ACT_WRITE   = 3'd3,
    ACT_READ    = 3'd4,
    ACT_ACK     = 3'd5,
    ACT_NACK    = 3'd6,
    ACT_WAITACK = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    REG_STRETCH_LIMIT  = 2'd0,
    REG_ACK_WAIT_LIMIT = 2'd1,
    REG_WRITE_LEAD     = 2'd2,
    REG_READ_LEAD      = 2'd3
  } reg_idx_e;

  localparam logic [WAIT_W-1:0] STRETCH_LIMIT_RST  = 16'd19999;
  localparam logic [WAIT_W-1:0] ACK_WAIT_LIMIT_RST = 16'd100;
  localparam logic [LEAD_W-1:0] WRITE_LEAD_RST     = 8'd10;
  localparam logic [LEAD_W-1:0] READ_LEAD_RST      = 8'd20;

  typedef struct packed {
    action_e                action;
    logic [DATA_BITS-1:0]   tx_byte;
    logic                   scl_in;
    logic                   sda_in;
  } item_t;

  typedef struct packed {
    logic [WAIT_W-1:0]      stretch_limit;
    logic [WAIT_W-1:0]      ack_wait_limit;
    logic [LEAD_W-1:0]      write_lead_ticks;
    logic [LEAD_W-1:0]      read_lead_ticks;
  } cfg_t;

  typedef struct packed {
    logic                   scl_out;
    logic                   sda_out;
    logic                   busy_res;
    logic                   done_res;
    logic                   success;
    logic [DATA_BITS-1:0]   rx_byte;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/i2cbs_if.sv =====
// ----------------------------------------------------------------------------
// I2C bit sequencer channel interfaces
// Command, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cbs_cmd_if;
  logic                                 valid;
  logic                                 ready;
  i2cbs_pkg::action_e                   action;
  logic [i2cbs_pkg::DATA_BITS-1:0]      tx_byte;
  logic                                 scl_in;
  logic                                 sda_in;

  modport source (output valid, action, tx_byte, scl_in, sda_in, input ready);
  modport sink   (input valid, action, tx_byte, scl_in, sda_in, output ready);
endinterface

interface i2cbs_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 scl_out;
  logic                                 sda_out;
  logic                                 busy_res;
  logic                                 done_res;
  logic                                 success;
  logic [i2cbs_pkg::DATA_BITS-1:0]      rx_byte;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, success, rx_byte,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, success, rx_byte,
                  output ready);
endinterface

interface i2cbs_cfg_if;
  logic                                 valid;
  logic                                 ready;
  i2cbs_pkg::reg_idx_e                  index;
  logic [i2cbs_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/i2cbs_cfg.sv =====
// ----------------------------------------------------------------------------
// I2C bit sequencer configuration registers
// Holds stretch and acknowledge limits and the read/write lead times.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  i2cbs_cfg_if.sink        cfg_i,
  output i2cbs_pkg::cfg_t  cfg_o
);
  import i2cbs_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stretch_limit    <= STRETCH_LIMIT_RST;
      cfg_q.ack_wait_limit   <= ACK_WAIT_LIMIT_RST;
      cfg_q.write_lead_ticks <= WRITE_LEAD_RST;
      cfg_q.read_lead_ticks  <= READ_LEAD_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_STRETCH_LIMIT:  cfg_q.stretch_limit    <= cfg_i.data[WAIT_W-1:0];
        REG_ACK_WAIT_LIMIT: cfg_q.ack_wait_limit   <= cfg_i.data[WAIT_W-1:0];
        REG_WRITE_LEAD:     cfg_q.write_lead_ticks <= cfg_i.data[LEAD_W-1:0];
        REG_READ_LEAD:      cfg_q.read_lead_ticks  <= cfg_i.data[LEAD_W-1:0];
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i2cbs_seq.sv =====
// ----------------------------------------------------------------------------
// I2C bit sequencer core
// Command state and pin levels; one transaction advances them by one step.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire i2cbs_pkg::item_t item_i,
  input  wire i2cbs_pkg::cfg_t  cfg_i,
  output i2cbs_pkg::result_t  result_o
);
  import i2cbs_pkg::*;

  typedef enum logic [2:0] {
    STEP_0 = 3'd0,
    STEP_1 = 3'd1,
    STEP_2 = 3'd2,
    STEP_3 = 3'd3,
    STEP_4 = 3'd4
  } step_e;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(DATA_BITS);

  action_e                cmd_q, cmd_d;
  step_e                  step_q, step_d;
  logic [BIT_IDX_W-1:0]   bit_q, bit_d;
  logic [DATA_BITS-1:0]   tx_q, tx_d;
  logic [DATA_BITS-1:0]   rx_q, rx_d;
  logic [WAIT_W-1:0]      wait_q, wait_d;
  logic [LEAD_W-1:0]      lead_q, lead_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic                   fail_q, fail_d;
  logic                   done;
  logic                   ok;

  always_comb begin
    cmd_d  = cmd_q;
    step_d = step_q;
    bit_d  = bit_q;
    tx_d   = tx_q;
    rx_d   = rx_q;
    wait_d = wait_q;
    lead_d = lead_q;
    scl_d  = scl_q;
    sda_d  = sda_q;
    fail_d = fail_q;
    done   = 1'b0;
    ok     = 1'b0;
    if (step_i) begin
      if (item_i.action == ACT_TICK) begin
        unique case (cmd_q)
          ACT_TICK: begin
          end
          ACT_START: begin
            unique case (step_q)
              STEP_0: begin scl_d = 1'b1; step_d = STEP_1; end
              STEP_1: begin sda_d = 1'b0; step_d = STEP_2; end
              STEP_2: begin scl_d = 1'b0; step_d = STEP_3; end
              default: begin cmd_d = ACT_TICK; step_d = STEP_0; done = 1'b1; ok = 1'b1; end
            endcase
          end
          ACT_STOP: begin
            unique case (step_q)
              STEP_0: begin
                scl_d  = 1'b1;
                wait_d = '0;
                step_d = STEP_1;
              end
              STEP_1: begin
                if (item_i.scl_in) begin
                  step_d = STEP_2;
                end else if (wait_q >= cfg_i.stretch_limit) begin
                  cmd_d = ACT_TICK; step_d = STEP_0; done = 1'b1;
                end else begin
                  wait_d = wait_q + 16'd1;
                end
              end
              STEP_2: begin sda_d = 1'b1; step_d = STEP_3; end
              default: begin cmd_d = ACT_TICK; step_d = STEP_0; done = 1'b1; ok = !fail_q; end
            endcase
          end
          ACT_WRITE: begin
            unique case (step_q)
              STEP_0: begin
                lead_d = lead_q + 8'd1;
                if (lead_d >= cfg_i.write_lead_ticks) begin
                  sda_d  = tx_q[DATA_BITS-1];
                  step_d = STEP_1;
                end
              end
              STEP_1: begin scl_d = 1'b1; step_d = STEP_2; end
              STEP_2: step_d = STEP_3;
              STEP_3: begin
                scl_d  = 1'b0;
                tx_d   = {tx_q[DATA_BITS-2:0], 1'b0};
                step_d = STEP_4;
              end
              default: begin
                bit_d = bit_q + 4'd1;
                if (bit_d >= LAST_BIT) begin
                  cmd_d = ACT_TICK; step_d = STEP_0; done = 1'b1; ok = 1'b1;
                end else begin
                  sda_d  = tx_q[DATA_BITS-1];
                  step_d = STEP_1;
                end
              end
            endcase
          end
          ACT_READ: begin
            unique case (step_q)
              STEP_0: begin
                lead_d = lead_q + 8'd1;
                if (lead_d >= cfg_i.read_lead_ticks) begin
                  scl_d  = 1'b0;
                  step_d = STEP_1;
                end
              end
              STEP_1: begin
                scl_d  = 1'b1;
                wait_d = '0;
                step_d = STEP_2;
              end
              STEP_2: begin
                if (item_i.scl_in) begin
                  rx_d   = {rx_q[DATA_BITS-2:0], item_i.sda_in};
                  step_d = STEP_3;
                end else if (wait_q >= cfg_i.stretch_limit) begin
                  cmd_d = ACT_TICK; step_d = STEP_0; done = 1'b1;
                end else begin
                  wait_d = wait_q + 16'd1;
                end
              end
              default: begin
                bit_d = bit_q + 4'd1;
                scl_d = 1'b0;
                if (bit_d >= LAST_BIT) begin
                  cmd_d = ACT_TICK; step_d = STEP_0; done = 1'b1; ok = 1'b1;
                end else begin
                  step_d = STEP_1;
                end
              end
            endcase
          end
          ACT_ACK, ACT_NACK: begin
            unique case (step_q)
              STEP_0: begin sda_d = (cmd_q == ACT_NACK); step_d = STEP_1; end
              STEP_1: begin scl_d = 1'b1; step_d = STEP_2; end
              STEP_2: begin scl_d = 1'b0; step_d = STEP_3; end
              default: begin cmd_d = ACT_TICK; step_d = STEP_0; done = 1'b1; ok = 1'b1; end
            endcase
          end
          ACT_WAITACK: begin
            unique case (step_q)
              STEP_0: begin
                scl_d  = 1'b1;
                wait_d = '0;
                step_d = STEP_1;
              end
              STEP_1: begin
                // SCL seen high: SDA is sampled at once; if still high, the STEP_2 polls start with wait_q at 1
                if (item_i.scl_in) begin
                  if (!item_i.sda_in) begin
                    wait_d = '0;
                    step_d = STEP_3;
                  end else begin
                    wait_d = 16'd1;
                    step_d = STEP_2;
                  end
                end else if (wait_q >= cfg_i.stretch_limit) begin
                  cmd_d = ACT_TICK; step_d = STEP_0; done = 1'b1;
                end else begin
                  wait_d = wait_q + 16'd1;
                end
              end
              STEP_2: begin
                if (!item_i.sda_in) begin
                  step_d = STEP_3;
                end else if (wait_q > cfg_i.ack_wait_limit) begin
                  // no acknowledge: release the bus with a stop, then fail
                  sda_d  = 1'b0;
                  fail_d = 1'b1;
                  cmd_d  = ACT_STOP;
                  step_d = STEP_0;
                end else begin
                  wait_d = wait_q + 16'd1;
                end
              end
              STEP_3: begin scl_d = 1'b0; step_d = STEP_4; end
              default: begin cmd_d = ACT_TICK; step_d = STEP_0; done = 1'b1; ok = 1'b1; end
            endcase
          end
        endcase
      end else if (cmd_q == ACT_TICK) begin
        cmd_d  = item_i.action;
        step_d = STEP_0;
        bit_d  = '0;
        lead_d = '0;
        wait_d = '0;
        fail_d = 1'b0;
        unique case (item_i.action)
          ACT_START, ACT_WAITACK: sda_d = 1'b1;
          ACT_STOP:               sda_d = 1'b0;
          ACT_WRITE: begin
            tx_d = item_i.tx_byte;
            if (cfg_i.write_lead_ticks == '0) begin
              sda_d  = item_i.tx_byte[DATA_BITS-1];
              step_d = STEP_1;
            end
          end
          ACT_READ: begin
            sda_d = 1'b1;
            if (cfg_i.read_lead_ticks == '0) begin
              scl_d  = 1'b0;
              step_d = STEP_1;
            end
          end
          default: scl_d = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q  <= ACT_TICK;
      step_q <= STEP_0;
      bit_q  <= '0;
      tx_q   <= '0;
      rx_q   <= '0;
      wait_q <= '0;
      lead_q <= '0;
      scl_q  <= 1'b1;
      sda_q  <= 1'b1;
      fail_q <= 1'b0;
    end else begin
      cmd_q  <= cmd_d;
      step_q <= step_d;
      bit_q  <= bit_d;
      tx_q   <= tx_d;
      rx_q   <= rx_d;
      wait_q <= wait_d;
      lead_q <= lead_d;
      scl_q  <= scl_d;
      sda_q  <= sda_d;
      fail_q <= fail_d;
    end
  end

  assign result_o.scl_out  = scl_d;
  assign result_o.sda_out  = sda_d;
  assign result_o.busy_res = (cmd_d != ACT_TICK);
  assign result_o.done_res = done;
  assign result_o.success  = done & ok;
  assign result_o.rx_byte  = rx_d;

endmodule

`default_nettype wire

// ===== hdl/i2c_master_bit_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Open-drain I2C master pin sequencer with clock stretching support.
//
// cmd_i carries one transaction per item: a tick (one delay unit, with the
// sampled SCL/SDA levels) or a command, taken only while no command runs.
// res_o returns exactly one transaction per item: SCL/SDA drive levels,
// busy, done, success and the read shift register.
// cfg_i writes the stretch limit, ack wait limit and the write/read lead
// times; it is always ready, and the user must write it only while the
// block is idle, which the block itself does not enforce. Items pass the
// input register and then the result register. Throughput is one item per
// cycle while res_o does not stall, set by the core's state update between
// the two registers. Reset releases both pins, clears the command state and
// empties both registers. On a res_o stall the result register holds and
// a full input register keeps one item while cmd_i drops ready.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer_top (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  i2cbs_cmd_if.sink     cmd_i,
  i2cbs_res_if.source   res_o,
  i2cbs_cfg_if.sink     cfg_i
);
  import i2cbs_pkg::*;

  cfg_t     cfg;
  item_t    item_q;
  logic     in_valid_q;
  logic     out_valid_q;
  result_t  res_q;
  result_t  seq_res;
  logic     advance;
  logic     step;

  assign advance     = !out_valid_q || res_o.ready;
  assign step        = in_valid_q && advance;
  assign cmd_i.ready = !in_valid_q || advance;

  i2cbs_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  i2cbs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (seq_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.valid && cmd_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      item_q.action  <= cmd_i.action;
      item_q.tx_byte <= cmd_i.tx_byte;
      item_q.scl_in  <= cmd_i.scl_in;
      item_q.sda_in  <= cmd_i.sda_in;
    end
    if (step) begin
      res_q <= seq_res;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.scl_out  = res_q.scl_out;
  assign res_o.sda_out  = res_q.sda_out;
  assign res_o.busy_res = res_q.busy_res;
  assign res_o.done_res = res_q.done_res;
  assign res_o.success  = res_q.success;
  assign res_o.rx_byte  = res_q.rx_byte;

endmodule

`default_nettype wire

// ===== hdl/i2cbs_checker.sv =====
// ----------------------------------------------------------------------------
// I2C bit sequencer port checker
// Watches the top-level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_bit_sequencer_top_macros.svh"

module i2cbs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cmd_valid_i,
  input wire logic        cmd_ready_i,
  input wire logic        res_valid_i,
  input wire logic        res_ready_i,
  input wire logic        res_scl_i,
  input wire logic        res_sda_i,
  input wire logic        res_busy_i,
  input wire logic        res_done_i,
  input wire logic        res_success_i,
  input wire logic [7:0]  res_rx_i
);

  logic        cmd_fire;
  logic        res_stall;
  logic        res_bad_flags;
  logic [12:0] res_payload;

  assign cmd_fire      = cmd_valid_i && cmd_ready_i;
  assign res_stall     = res_valid_i && !res_ready_i;
  assign res_bad_flags = (res_done_i && res_busy_i) || (res_success_i && !res_done_i);
  assign res_payload   = {res_scl_i, res_sda_i, res_busy_i, res_done_i, res_success_i, res_rx_i};

  // a stalled result transaction holds its payload
  `I2CBS_ASSERT(a_res_hold, res_stall |=> res_valid_i && $stable(res_payload), "result changed while stalled")

  // each accepted item shows up as a valid result behind the input and result registers unless the output stalls
  `I2CBS_ASSERT(a_latency, cmd_fire ##1 !res_stall |=> res_valid_i, "result missing after item")

  // the command side only stalls behind a stalled result
  `I2CBS_ASSERT_NEVER(a_no_idle_stall, !cmd_ready_i && !res_stall, "command stalled without backpressure")

  // a finished command leaves the sequencer idle, success only with done
  `I2CBS_ASSERT_NEVER(a_done_idle, res_valid_i && res_bad_flags, "done/success inconsistent with busy")

endmodule

bind i2c_master_bit_sequencer_top i2cbs_checker u_i2cbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd_i.valid),
  .cmd_ready_i   (cmd_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_scl_i     (res_o.scl_out),
  .res_sda_i     (res_o.sda_out),
  .res_busy_i    (res_o.busy_res),
  .res_done_i    (res_o.done_res),
  .res_success_i (res_o.success),
  .res_rx_i      (res_o.rx_byte)
);

`default_nettype wire
